/* rtl/npc_pkg.sv */
// Shared types, widths and constants for the nearest plane point classifier.
package npc_pkg;

  // Default number of plane cells in the chain
  localparam int unsigned PlaneSlotsDef = 64;
  // Slots reachable by the 6-bit entry index and plane limit registers
  localparam int unsigned MaxSlots = 64;

  // Field widths
  localparam int unsigned IdxW   = 6;
  localparam int unsigned CntW   = 7;
  localparam int unsigned DistW  = 31;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned CoordW = 32;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // Distance arithmetic: Q1.15 * Q16.16 products, three products plus offset
  localparam int unsigned ProdW     = CoefW + CoordW;
  localparam int unsigned SumW      = ProdW + 2;
  localparam int unsigned FracShift = 15;
  localparam int unsigned RndW      = SumW - FracShift;
  localparam logic [SumW-1:0]  RoundBias = SumW'(1) << (FracShift - 1);
  localparam logic [DistW-1:0] DistMax   = {DistW{1'b1}};

  // Register reset values
  localparam logic [DistW-1:0] ThresholdRst   = DistW'(328);
  localparam logic [IdxW-1:0]  MaxIndexRst    = IdxW'(63);
  localparam logic [CntW-1:0]  PlanesValidRst = CntW'(0);

  // Action codes of an input transaction
  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_CLASSIFY = 1'b1;

  // Configuration register indexes (word address)
  typedef enum logic [1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_MAX_INDEX    = 2'd1,
    REG_PLANES_VALID = 2'd2
  } npc_reg_e;

  // One plane equation a*x + b*y + c*z + d
  typedef struct packed {
    logic signed [CoefW-1:0]  nx;
    logic signed [CoefW-1:0]  ny;
    logic signed [CoefW-1:0]  nz;
    logic signed [CoordW-1:0] d;
  } plane_t;

  // Point under classification
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             found;
    logic             done;
    logic [IdxW-1:0]  best_j;
    logic [DistW-1:0] best_d;
  } scan_t;

endpackage

/* rtl/npc_in_if.sv */
// Input channel: plane load and point classify transactions.
interface npc_in_if import npc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [IdxW-1:0]          entry_index;
  logic signed [CoefW-1:0]  normal_x;
  logic signed [CoefW-1:0]  normal_y;
  logic signed [CoefW-1:0]  normal_z;
  logic signed [CoordW-1:0] plane_offset;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [CoordW-1:0] point_z;

  modport source (
    output valid, action, entry_index, normal_x, normal_y, normal_z,
    output plane_offset, point_x, point_y, point_z,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, normal_x, normal_y, normal_z,
    input  plane_offset, point_x, point_y, point_z,
    output ready
  );
endinterface

/* rtl/npc_out_if.sv */
// Output channel: classification result transactions.
interface npc_out_if import npc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  plane_index;
  logic [DistW-1:0] plane_distance;

  modport source (output valid, plane_index, plane_distance, input ready);
  modport sink   (input valid, plane_index, plane_distance, output ready);
endinterface

/* rtl/npc_cell.sv */
// One chain cell: holds a plane, computes its distance to the point, updates the token.
module npc_cell import npc_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  point_t           point_i,
  input  logic             plane_wr_i,
  input  logic [IdxW-1:0]  entry_index_i,
  input  plane_t           plane_i,
  input  logic [CntW-1:0]  limit_i,
  input  logic [DistW-1:0] thr_i,
  input  scan_t            tok_i,
  output scan_t            tok_o
);

  // Cells past the addressable range park at MaxSlots and never match or search
  localparam logic [CntW-1:0] SlotId =
    CntW'((CELL_IDX < MaxSlots) ? CELL_IDX : MaxSlots);

  plane_t                   plane_q;
  logic signed [ProdW-1:0]  prod_x_q, prod_y_q, prod_z_q;
  logic signed [CoordW-1:0] offs_q;
  logic signed [SumW-1:0]   sum_q;
  logic [SumW-1:0]          mag, rnd;
  logic [RndW-1:0]          quo;
  logic [DistW-1:0]         dist_d, dist_q;
  logic                     active, take;
  scan_t                    tok_d, tok_q;

  // Plane storage, written by a load transaction addressed to this slot
  always_ff @(posedge clk_i) begin
    if (plane_wr_i && ({1'b0, entry_index_i} == SlotId)) begin
      plane_q <= plane_i;
    end
  end

  // Stage 1: coefficient times coordinate
  always_ff @(posedge clk_i) begin
    prod_x_q <= ProdW'(plane_q.nx) * ProdW'(point_i.x);
    prod_y_q <= ProdW'(plane_q.ny) * ProdW'(point_i.y);
    prod_z_q <= ProdW'(plane_q.nz) * ProdW'(point_i.z);
    offs_q   <= plane_q.d;
  end

  // Stage 2: exact sum, offset aligned to the product scale
  always_ff @(posedge clk_i) begin
    sum_q <= SumW'(prod_x_q) + SumW'(prod_y_q) + SumW'(prod_z_q)
           + (SumW'(offs_q) <<< FracShift);
  end

  // Stage 3: magnitude, round to Q16.16, saturate
  always_comb begin
    mag    = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
    rnd    = mag + RoundBias;
    quo    = rnd[SumW-1:FracShift];
    dist_d = (|quo[RndW-1:DistW]) ? DistMax : quo[DistW-1:0];
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  // Token update: keep nearest plane, earlier wins ties, stop below threshold
  always_comb begin
    active = SlotId < limit_i;
    take   = !tok_i.found || (dist_q < tok_i.best_d);
    tok_d  = tok_i;
    if (tok_i.valid && active && !tok_i.done) begin
      if (take) begin
        tok_d.best_d = dist_q;
        tok_d.best_j = IdxW'(CELL_IDX);
      end
      tok_d.found = 1'b1;
      tok_d.done  = tok_d.best_d < thr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  // A token leaves only in the cycle after one arrived
  a_tok_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_q.valid |-> $past(tok_i.valid))
    else $error("token out without token in");

  // A finished search always carries a match
  a_done_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_q.valid && tok_q.done) |-> tok_q.found)
    else $error("search stopped without a match");

  // The best distance never grows along the chain
  a_best_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_q.valid && $past(tok_i.valid && tok_i.found))
      |-> (tok_q.best_d <= $past(tok_i.best_d)))
    else $error("best distance grew");

endmodule

/* rtl/nearest_plane_point_classifier.sv */
// Nearest plane point classifier: a load transaction writes one plane into the cell of its
// slot. A classify transaction latches the point, which every cell sees at once; each cell
// forms its plane distance in a three-stage multiply/add/round pipeline. A search token
// then walks the chain of PLANE_SLOTS cells, one cell per cycle, keeping the nearest
// active plane and stopping its updates at the first plane closer than the threshold. No
// transaction is accepted while a classify is in the warm-up, scan or drain states, and a
// held output can stall the drain. A finished result waits in the output register while
// the next transaction is accepted.
module nearest_plane_point_classifier import npc_pkg::*; #(
  parameter int unsigned PLANE_SLOTS = PlaneSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  npc_in_if.sink              req_i,
  npc_out_if.source           rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam logic [CntW-1:0] SlotCap =
    CntW'((PLANE_SLOTS < MaxSlots) ? PLANE_SLOTS : MaxSlots);
  localparam logic [1:0] WarmLast = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WARM  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DRAIN = 4'b1000
  } npc_state_e;

  npc_state_e       state_q, state_d;
  logic [1:0]       warm_q, warm_d;
  logic             launch_q, launch_d;
  logic [DistW-1:0] thr_q;
  logic [IdxW-1:0]  max_idx_q;
  logic [CntW-1:0]  planes_valid_q;
  logic [CntW-1:0]  lim_a, lim_b, limit;
  logic             cfg_wr;
  point_t           point_q;
  plane_t           plane_in;
  logic             req_acc, load_wr, classify_acc;
  scan_t            chain [PLANE_SLOTS+1];
  scan_t            chain_end;
  logic             res_hit_q;
  logic [IdxW-1:0]  res_idx_q;
  logic [DistW-1:0] res_dist_q;
  logic             out_valid_q, out_load;
  logic [IdxW-1:0]  out_idx_q;
  logic [DistW-1:0] out_dist_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q          <= ThresholdRst;
      max_idx_q      <= MaxIndexRst;
      planes_valid_q <= PlanesValidRst;
    end else if (cfg_wr) begin
      case (npc_reg_e'(paddr[3:2]))
        REG_THRESHOLD:    thr_q          <= pwdata[DistW-1:0];
        REG_MAX_INDEX:    max_idx_q      <= pwdata[IdxW-1:0];
        REG_PLANES_VALID: planes_valid_q <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (npc_reg_e'(paddr[3:2]))
      REG_THRESHOLD:    prdata = ApbDataW'(thr_q);
      REG_MAX_INDEX:    prdata = ApbDataW'(max_idx_q);
      REG_PLANES_VALID: prdata = ApbDataW'(planes_valid_q);
      default:          prdata = '0;
    endcase
  end

  // Number of planes searched
  always_comb begin
    lim_a = {1'b0, max_idx_q} + CntW'(1);
    lim_b = (planes_valid_q < lim_a) ? planes_valid_q : lim_a;
    limit = (SlotCap < lim_b) ? SlotCap : lim_b;
  end

  // Input transaction handling
  assign req_i.ready  = (state_q == ST_IDLE);
  assign req_acc      = req_i.valid && req_i.ready;
  assign load_wr      = req_acc && (req_i.action == ACT_LOAD);
  assign classify_acc = req_acc && (req_i.action == ACT_CLASSIFY);

  assign plane_in = '{nx: req_i.normal_x, ny: req_i.normal_y, nz: req_i.normal_z,
                      d: req_i.plane_offset};

  always_ff @(posedge clk_i) begin
    if (classify_acc) begin
      point_q <= '{x: req_i.point_x, y: req_i.point_y, z: req_i.point_z};
    end
  end

  // Cell chain
  assign chain[0] = '{valid: launch_q, found: 1'b0, done: 1'b0,
                      best_j: '0, best_d: '0};

  for (genvar k = 0; k < PLANE_SLOTS; k++) begin : g_cell
    npc_cell #(.CELL_IDX(k)) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .point_i       (point_q),
      .plane_wr_i    (load_wr),
      .entry_index_i (req_i.entry_index),
      .plane_i       (plane_in),
      .limit_i       (limit),
      .thr_i         (thr_q),
      .tok_i         (chain[k]),
      .tok_o         (chain[k+1])
    );
  end

  assign chain_end = chain[PLANE_SLOTS];

  // Sequencer
  always_comb begin
    state_d  = state_q;
    warm_d   = warm_q;
    launch_d = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (classify_acc) begin
          state_d = ST_WARM;
          warm_d  = '0;
        end
      end
      ST_WARM: begin
        warm_d = warm_q + 2'd1;
        if (warm_q == WarmLast) begin
          launch_d = 1'b1;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain_end.valid) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!res_hit_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      warm_q   <= '0;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      warm_q   <= warm_d;
      launch_q <= launch_d;
    end
  end

  // Capture of the search outcome at the chain end
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && chain_end.valid) begin
      res_hit_q  <= chain_end.found && (chain_end.best_d <= thr_q);
      res_idx_q  <= chain_end.best_j;
      res_dist_q <= chain_end.best_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= res_idx_q;
      out_dist_q <= res_dist_q;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.plane_index    = out_idx_q;
  assign rsp_o.plane_distance = out_dist_q;

  // The token is launched only when the sequencer is scanning
  a_launch_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q |-> (state_q == ST_SCAN))
    else $error("token launched outside scan");

  // The chain end delivers only during a scan
  a_end_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_end.valid |-> (state_q == ST_SCAN))
    else $error("chain result outside scan");

  // A new result appears only from a hit being drained
  a_out_from_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DRAIN && res_hit_q))
    else $error("result without a hit");

endmodule

/* tb/tb_nearest_plane_point_classifier.sv */
// Self-checking testbench for the nearest plane point classifier.
module tb_nearest_plane_point_classifier;
  import npc_pkg::*;

  // Cycles one classify transaction may keep the cell chain busy, plus margin
  localparam int unsigned DrainCycles = PlaneSlotsDef + 16;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned LimitCycles = 1000000;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_HIT
  } chk_e;

  typedef enum logic {
    ROW_SEND,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [DistW-1:0] distance;
  } plane_hit_t;

  typedef struct packed {
    logic            action;
    logic [IdxW-1:0] slot;
    plane_t          pl;
    point_t          pt;
  } req_t;

  // Directed row: load (a..d = normals, offset), classify (a..c = point), config (a = value)
  typedef struct {
    row_kind_e   kind;
    logic        action;
    logic [5:0]  slot;
    logic [31:0] a, b, c, d;
    npc_reg_e    cfg_reg;
    chk_e        chk;
    plane_hit_t  hit;
  } dir_row_t;

  typedef struct {
    logic [DistW-1:0] cut;
    logic [IdxW-1:0]  last;
    logic [CntW-1:0]  loaded;
    int               n;
    bit               idle;
    bit               hold;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel, penable, pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  npc_in_if  req_if ();
  npc_out_if rsp_if ();

  nearest_plane_point_classifier uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state
  plane_t           plane_tab [PlaneSlotsDef];
  logic [DistW-1:0] cut_dist      = ThresholdRst;
  logic [IdxW-1:0]  last_plane    = MaxIndexRst;
  logic [CntW-1:0]  planes_loaded = PlanesValidRst;

  plane_hit_t hits_due [$];
  int         mismatches = 0;

  // Sideband that travels with the offered transaction
  chk_e       row_chk;
  plane_hit_t row_hit;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;

  dir_row_t dir_rows [$];
  phase_t   phases [$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Rounded, saturated |a*x + b*y + c*z + d| in Q16.16
  function automatic logic [DistW-1:0] plane_gap(input plane_t p, input point_t q);
    longint      a, b, c, d, x, y, z, s;
    logic [63:0] mag, rnd;
    a = p.nx; b = p.ny; c = p.nz; d = p.d;
    x = q.x; y = q.y; z = q.z;
    s = a * x + b * y + c * z + d * 32768;
    mag = (s < 0) ? -s : s;
    rnd = (mag + 64'd16384) >> 15;
    return (rnd > 64'h7FFF_FFFF) ? DistMax : rnd[DistW-1:0];
  endfunction

  function automatic int active_planes();
    int n;
    n = int'(last_plane) + 1;
    if (int'(planes_loaded) < n) n = int'(planes_loaded);
    if (PlaneSlotsDef < n) n = PlaneSlotsDef;
    return n;
  endfunction

  // Scan in table order; the earlier plane keeps ties, stop once under the cut
  function automatic bit nearest_plane(input point_t q, output plane_hit_t h);
    bit               found;
    logic [DistW-1:0] gap;
    int               n;
    found = 1'b0;
    h = '0;
    n = active_planes();
    for (int j = 0; j < n; j++) begin
      gap = plane_gap(plane_tab[j], q);
      if (!found || gap < h.distance) begin
        h.distance = gap;
        h.idx = IdxW'(j);
        found = 1'b1;
      end
      if (h.distance < cut_dist) break;
    end
    return found && (h.distance <= cut_dist);
  endfunction

  function automatic plane_t rand_plane();
    plane_t p;
    int     mag;
    p.nx = CoefW'($urandom);
    p.ny = CoefW'($urandom);
    p.nz = CoefW'($urandom);
    p.d  = $urandom;
    // Mostly planes with a strong z term so points can be placed on them
    if ($urandom_range(0, 7) != 0) begin
      mag = $urandom_range(8192, 32768);
      p.nz = $urandom_range(0, 1) ? CoefW'(mag) : CoefW'(-mag);
      p.d = p.d >>> $urandom_range(3, 31);
    end
    return p;
  endfunction

  // Point placed near one of the planes, solved for z and jittered
  function automatic point_t near_point();
    point_t q;
    plane_t p;
    longint a, b, c, d, x, y, z;
    int     n, jitter;
    n = active_planes();
    if (n == 0 || $urandom_range(0, 7) == 0) n = PlaneSlotsDef;
    p = plane_tab[$urandom_range(0, n - 1)];
    q.x = $urandom;
    q.y = $urandom;
    q.z = $urandom;
    if ($urandom_range(0, 7) != 0) begin
      q.x = CoordW'($signed(21'($urandom)));
      q.y = CoordW'($signed(21'($urandom)));
    end
    a = p.nx; b = p.ny; c = p.nz; d = p.d;
    x = q.x; y = q.y;
    jitter = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 800)) - 400;
    if (c != 0) begin
      z = -(a * x + b * y + d * 32768) / c + jitter;
      if (z > 64'sd2147483647) z = 64'sd2147483647;
      if (z < -64'sd2147483648) z = -64'sd2147483648;
      q.z = z[31:0];
    end
    return q;
  endfunction

  function automatic req_t rand_req();
    req_t        r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    r.action = ACT_CLASSIFY;
    r.slot = IdxW'($urandom);
    r.pl = rand_plane();
    r.pt = '{$urandom, $urandom, $urandom};
    if (roll < 20) r.action = ACT_LOAD;
    else if (roll < 85) r.pt = near_point();
    return r;
  endfunction

  function automatic dir_row_t mk_load(input logic [5:0] slot, input logic [15:0] nx,
                                       input logic [15:0] ny, input logic [15:0] nz,
                                       input logic [31:0] off);
    return '{ROW_SEND, ACT_LOAD, slot, {16'd0, nx}, {16'd0, ny}, {16'd0, nz}, off,
             REG_THRESHOLD, CHK_NONE, '0};
  endfunction

  function automatic dir_row_t mk_point(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z, input chk_e chk,
                                        input plane_hit_t hit);
    return '{ROW_SEND, ACT_CLASSIFY, 6'd0, x, y, z, 32'd0, REG_THRESHOLD, chk, hit};
  endfunction

  function automatic dir_row_t mk_cfg(input npc_reg_e r, input logic [31:0] v);
    return '{ROW_CFG, ACT_LOAD, 6'd0, v, 32'd0, 32'd0, 32'd0, r, CHK_NONE, '0};
  endfunction

  // Append one directed row to the stimulus table
  task automatic add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Append one random phase
  task automatic add_phase(input phase_t ph);
    phases.insert(phases.size(), ph);
  endtask

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one transaction and return at the edge where it is taken
  task automatic send_item(input req_t it, input chk_e chk, input plane_hit_t hit);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= it.action;
    req_if.entry_index  <= it.slot;
    req_if.normal_x     <= it.pl.nx;
    req_if.normal_y     <= it.pl.ny;
    req_if.normal_z     <= it.pl.nz;
    req_if.plane_offset <= it.pl.d;
    req_if.point_x      <= it.pt.x;
    req_if.point_y      <= it.pt.y;
    req_if.point_z      <= it.pt.z;
    row_chk             <= chk;
    row_hit             <= hit;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Wait for outstanding results and for any silent classify still in the chain
  task automatic settle();
    req_if.valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input npc_reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({r, 2'b00});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (r)
      REG_THRESHOLD:    cut_dist = v[DistW-1:0];
      REG_MAX_INDEX:    last_plane = v[IdxW-1:0];
      REG_PLANES_VALID: planes_loaded = v[CntW-1:0];
      default: ;
    endcase
  endtask

  // Result check, then prediction of the transaction taken at this edge
  always @(posedge clk_i) begin : check_and_predict
    plane_hit_t got, want, pred;
    point_t     pt;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.idx = rsp_if.plane_index;
        got.distance = rsp_if.plane_distance;
        if (hits_due.size() == 0) begin
          note_mismatch("unexpected result, plane_index", got.idx, -1);
        end else begin
          want = hits_due.pop_front();
          if (got.idx !== want.idx) note_mismatch("plane_index", got.idx, want.idx);
          if (got.distance !== want.distance) begin
            note_mismatch("plane_distance", got.distance, want.distance);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        if (req_if.action == ACT_LOAD) begin
          plane_tab[req_if.entry_index] = '{req_if.normal_x, req_if.normal_y,
                                            req_if.normal_z, req_if.plane_offset};
        end else if (row_chk == CHK_HIT) begin
          hits_due.insert(hits_due.size(), row_hit);
        end else if (row_chk == CHK_MODEL) begin
          pt = '{req_if.point_x, req_if.point_y, req_if.point_z};
          if (nearest_plane(pt, pred)) hits_due.insert(hits_due.size(), pred);
        end
      end
    end
  end

  // Result side: random short stalls, one long hold-off on request
  initial begin
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Run watchdog
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < LimitCycles) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("nearest_plane_point_classifier test failed");
    $finish;
  end

  initial begin : stimulus
    req_t it;
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_LOAD;
    req_if.entry_index  <= '0;
    req_if.normal_x     <= '0;
    req_if.normal_y     <= '0;
    req_if.normal_z     <= '0;
    req_if.plane_offset <= '0;
    req_if.point_x      <= '0;
    req_if.point_y      <= '0;
    req_if.point_z      <= '0;
    row_chk             <= CHK_NONE;
    row_hit             <= '0;

    // Directed: empty table, extreme planes and points, ties, threshold edges
    add_row(mk_point(32'd0, 32'd0, 32'd0, CHK_NONE, '0));
    add_row(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, CHK_NONE, '0));
    add_row(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, CHK_NONE, '0));
    add_row(mk_load(6'd0, 16'h0000, 16'h0000, 16'h8000, 32'h0000_0000));
    add_row(mk_load(6'd1, 16'h8000, 16'h0000, 16'h0000, 32'h7FFF_FFFF));
    add_row(mk_load(6'd2, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h8000_0000));
    add_row(mk_load(6'd3, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000));
    add_row(mk_load(6'd63, 16'h0000, 16'h7FFF, 16'h0000, 32'h0000_0000));
    add_row(mk_cfg(REG_PLANES_VALID, 32'd4));
    // plane 0 is z = 0, so its distance is |z|
    add_row(mk_point(32'd0, 32'd0, 32'd0, CHK_HIT, '{6'd0, 31'd0}));
    add_row(mk_point(32'd5, 32'd7, 32'd328, CHK_HIT, '{6'd0, 31'd328}));
    add_row(mk_point(32'd0, 32'd0, 32'd329, CHK_MODEL, '0));
    add_row(mk_point(32'h7FFF_FFFF, 32'd0, 32'd1000, CHK_MODEL, '0));
    add_row(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, CHK_MODEL, '0));
    add_row(mk_cfg(REG_THRESHOLD, 32'h7FFF_FFFF));
    // every plane saturates: first one wins the tie
    add_row(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, CHK_HIT,
                     '{6'd0, DistMax}));
    add_row(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, CHK_MODEL, '0));
    add_row(mk_cfg(REG_THRESHOLD, 32'd0));
    add_row(mk_point(32'd0, 32'd0, 32'd0, CHK_MODEL, '0));
    add_row(mk_point(32'd0, 32'd0, 32'd1, CHK_MODEL, '0));
    add_row(mk_cfg(REG_THRESHOLD, 32'd328));
    add_row(mk_cfg(REG_MAX_INDEX, 32'd0));
    add_row(mk_point(32'h7FFF_FFFF, 32'd0, 32'd1000, CHK_MODEL, '0));

    // Random phases: threshold, last index, loaded count, items, idling, hold-off
    add_phase('{31'd328, 6'd63, 7'd64, 300, 1'b1, 1'b0});
    add_phase('{DistW'($urandom_range(0, 4000)), IdxW'($urandom),
                CntW'($urandom_range(1, 64)), 200, 1'b1, 1'b0});
    add_phase('{31'd0, 6'd63, 7'd64, 150, 1'b1, 1'b0});
    add_phase('{DistMax, 6'd63, 7'd64, 150, 1'b1, 1'b0});
    add_phase('{31'd2000, 6'd0, 7'd64, 150, 1'b1, 1'b0});
    add_phase('{31'd328, 6'd63, 7'd0, 60, 1'b1, 1'b0});
    add_phase('{31'd1000, 6'd31, 7'd40, 200, 1'b1, 1'b1});
    add_phase('{DistW'($urandom_range(0, 100000)), IdxW'($urandom),
                CntW'($urandom_range(1, 64)), 200, 1'b1, 1'b0});
    add_phase('{31'd328, 6'd63, 7'd64, 200, 1'b0, 1'b0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        cfg_write(dir_rows[i].cfg_reg, dir_rows[i].a);
      end else begin
        it.action = dir_rows[i].action;
        it.slot = dir_rows[i].slot;
        if (dir_rows[i].action == ACT_LOAD) begin
          it.pl = '{dir_rows[i].a[15:0], dir_rows[i].b[15:0], dir_rows[i].c[15:0],
                    dir_rows[i].d};
          it.pt = '0;
        end else begin
          it.pl = '0;
          it.pt = '{dir_rows[i].a, dir_rows[i].b, dir_rows[i].c};
        end
        send_item(it, dir_rows[i].chk, dir_rows[i].hit);
      end
    end

    // Fill the whole table so any later search reads only written slots
    for (int s = 0; s < PlaneSlotsDef; s++) begin
      it = rand_req();
      it.action = ACT_LOAD;
      it.slot = IdxW'(s);
      send_item(it, CHK_MODEL, '0);
    end

    foreach (phases[k]) begin
      settle();
      cfg_write(REG_THRESHOLD, 32'(phases[k].cut));
      cfg_write(REG_MAX_INDEX, 32'(phases[k].last));
      cfg_write(REG_PLANES_VALID, 32'(phases[k].loaded));
      tx_idle = phases[k].idle;
      rx_idle = phases[k].idle;
      if (phases[k].hold) hold_req = 1'b1;
      repeat (phases[k].n) send_item(rand_req(), CHK_MODEL, '0);
    end

    settle();
    if (mismatches == 0 && hits_due.size() == 0) begin
      $display("nearest_plane_point_classifier test passed");
    end else begin
      $display("nearest_plane_point_classifier test failed");
    end
    $finish;
  end

endmodule
